@@ design/gpioee_pkg.sv @@
`default_nettype none

package gpioee_pkg;

  // fixed field widths of the transaction payloads
  localparam int unsigned WORD_W    = 24;
  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned PIN_IDX_W = 5;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned TOTAL_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // queued edge record: {pin, rising}
  localparam int unsigned EV_REC_W  = PIN_IDX_W + 1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_POLL      = 3'd0,
    OP_POP       = 3'd1,
    OP_WRITE_ALL = 3'd2,
    OP_WRITE_ONE = 3'd3,
    OP_READ      = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_BAD_PIN    = 3'd1,
    STAT_PWM_BUSY   = 3'd2,
    STAT_NOT_OUTPUT = 3'd3,
    STAT_EMPTY      = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTPUT_MASK = 3'd0,
    CFG_EVENT_EN    = 3'd1,
    CFG_RISE_EN     = 3'd2,
    CFG_FALL_EN     = 3'd3,
    CFG_PWM_BUSY    = 3'd4
  } cfg_idx_e;

endpackage

`default_nettype wire

@@ design/gpio_edge_event_controller_core.sv @@
// gpio edge event controller core
//
// input channel (in_valid_i / in_ready_o) carries one command transaction:
// poll, pop event, write all, write one or read state. output channel
// (out_valid_o / out_ready_i) returns exactly one result per command, in
// order. the user must write configuration registers (cfg_we_i, cfg_index_i,
// cfg_wdata_i) only while the core is idle; the core does not enforce this.
//
// poll walks the pins one per cycle through shift registers; each changed
// input pin with its edge enabled writes one record into the event queue
// ram unless the queue is full. pop reads the queue ram (registered read).
// one command is in flight at a time; in_ready_o is high only while the
// core is idle.
//
// a finished result sits in the output register; the core still takes the
// next command while the receiver stalls and holds its own result until
// the output register frees up.
// reset clears masks, pin state, prev levels, queue pointers and the pop
// count; the first poll after reset only captures the pin levels.

`default_nettype none

module gpio_edge_event_controller_core
  import gpioee_pkg::*;
#(
  parameter int unsigned NUM_PINS    = 24,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [WORD_W-1:0]     cfg_wdata_i,

  // command channel
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [OPCODE_W-1:0]   in_opcode_i,
  input  wire logic [WORD_W-1:0]     in_pin_levels_i,
  input  wire logic [WORD_W-1:0]     in_data_word_i,
  input  wire logic [PIN_IDX_W-1:0]  in_pin_index_i,
  input  wire logic                  in_pin_value_i,

  // result channel
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [STATUS_W-1:0]        out_status_o,
  output logic                       out_event_valid_o,
  output logic [PIN_IDX_W-1:0]       out_event_pin_o,
  output logic                       out_event_rising_o,
  output logic [TOTAL_W-1:0]         out_event_total_o,
  output logic [WORD_W-1:0]          out_state_word_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntLast = CntW'(NUM_PINS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_FINISH
  } state_e;

  // ---------------------------------------------------------------------
  // configuration registers, only the implemented pins are kept
  // ---------------------------------------------------------------------
  logic [NUM_PINS-1:0] out_mask_q, ev_en_q, rise_en_q, fall_en_q, pwm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_mask_q <= '0;
      ev_en_q    <= '0;
      rise_en_q  <= '0;
      fall_en_q  <= '0;
      pwm_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OUTPUT_MASK: out_mask_q <= cfg_wdata_i[NUM_PINS-1:0];
        CFG_EVENT_EN:    ev_en_q    <= cfg_wdata_i[NUM_PINS-1:0];
        CFG_RISE_EN:     rise_en_q  <= cfg_wdata_i[NUM_PINS-1:0];
        CFG_FALL_EN:     fall_en_q  <= cfg_wdata_i[NUM_PINS-1:0];
        CFG_PWM_BUSY:    pwm_q      <= cfg_wdata_i[NUM_PINS-1:0];
        default: ;  // unmapped index, write is dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------
  state_e               state_q, state_d;
  logic                 primed_q, primed_d;
  logic [NUM_PINS-1:0]  pin_state_q, pin_state_d;
  logic [NUM_PINS-1:0]  prev_q, prev_d;
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [TOTAL_W-1:0]   total_q, total_d;

  // scan shift registers, bit 0 is the pin under inspection
  logic [NUM_PINS-1:0]  lv_sh_q, lv_sh_d;
  logic [NUM_PINS-1:0]  pv_sh_q, pv_sh_d;
  logic [NUM_PINS-1:0]  om_sh_q, om_sh_d;
  logic [NUM_PINS-1:0]  ee_sh_q, ee_sh_d;
  logic [NUM_PINS-1:0]  re_sh_q, re_sh_d;
  logic [NUM_PINS-1:0]  fe_sh_q, fe_sh_d;
  logic [CntW-1:0]      pin_cnt_q, pin_cnt_d;

  // result held until the output register is free
  status_e              res_status_q, res_status_d;
  logic                 res_ev_valid_q, res_ev_valid_d;
  logic [PIN_IDX_W-1:0] res_ev_pin_q, res_ev_pin_d;
  logic                 res_ev_rising_q, res_ev_rising_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, out_status_d;
  logic                 out_ev_valid_q, out_ev_valid_d;
  logic [PIN_IDX_W-1:0] out_ev_pin_q, out_ev_pin_d;
  logic                 out_ev_rising_q, out_ev_rising_d;
  logic [TOTAL_W-1:0]   out_total_q, out_total_d;
  logic [WORD_W-1:0]    out_state_q, out_state_d;

  // event queue ram
  logic                 ram_we, ram_re;
  logic [EV_REC_W-1:0]  ram_wdata, ram_rdata;

  gpioee_ram #(
    .WIDTH (EV_REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // combinational helpers
  // ---------------------------------------------------------------------
  logic                now_bit, was_bit, pin_changed, push_req, new_state_bit;
  logic [PtrW-1:0]     wr_next, rd_next;
  logic                queue_full;
  logic [NUM_PINS-1:0] wr_all_mask, pin_sel, pin_levels;
  logic                pin_bad;

  always_comb begin
    now_bit       = lv_sh_q[0];
    was_bit       = pv_sh_q[0];
    // output pins never report, they only refresh prev levels
    pin_changed   = !om_sh_q[0] && (now_bit != was_bit);
    push_req      = pin_changed && ee_sh_q[0] && (now_bit ? re_sh_q[0] : fe_sh_q[0]);
    new_state_bit = pin_changed ? now_bit : pin_state_q[0];

    // ring pointers wrap at the queue depth, one slot stays free
    wr_next    = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    rd_next    = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    queue_full = (wr_next == rd_ptr_q);

    wr_all_mask = out_mask_q & ~pwm_q;
    pin_bad     = (in_pin_index_i >= PIN_IDX_W'(NUM_PINS));
    pin_sel     = NUM_PINS'(1) << in_pin_index_i;
    pin_levels  = in_pin_levels_i[NUM_PINS-1:0];
  end

  // pin counter widened to the record's pin field
  function automatic logic [PIN_IDX_W-1:0] EV_PIN_REC(logic [CntW-1:0] cnt);
    return PIN_IDX_W'(cnt);
  endfunction

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d         = state_q;
    primed_d        = primed_q;
    pin_state_d     = pin_state_q;
    prev_d          = prev_q;
    wr_ptr_d        = wr_ptr_q;
    rd_ptr_d        = rd_ptr_q;
    total_d         = total_q;
    lv_sh_d         = lv_sh_q;
    pv_sh_d         = pv_sh_q;
    om_sh_d         = om_sh_q;
    ee_sh_d         = ee_sh_q;
    re_sh_d         = re_sh_q;
    fe_sh_d         = fe_sh_q;
    pin_cnt_d       = pin_cnt_q;
    res_status_d    = res_status_q;
    res_ev_valid_d  = res_ev_valid_q;
    res_ev_pin_d    = res_ev_pin_q;
    res_ev_rising_d = res_ev_rising_q;
    out_valid_d     = out_valid_q;
    out_status_d    = out_status_q;
    out_ev_valid_d  = out_ev_valid_q;
    out_ev_pin_d    = out_ev_pin_q;
    out_ev_rising_d = out_ev_rising_q;
    out_total_d     = out_total_q;
    out_state_d     = out_state_q;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_wdata       = {EV_PIN_REC(pin_cnt_q), now_bit};

    // receiver took the pending result
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_status_d    = STAT_OK;
          res_ev_valid_d  = 1'b0;
          res_ev_pin_d    = '0;
          res_ev_rising_d = 1'b0;
          state_d         = ST_FINISH;
          case (op_e'(in_opcode_i))
            OP_POLL: begin
              // every implemented pin ends the poll with prev = sample
              prev_d = pin_levels;
              if (!primed_q) begin
                primed_d = 1'b1;
              end else begin
                lv_sh_d   = pin_levels;
                pv_sh_d   = prev_q;
                om_sh_d   = out_mask_q;
                ee_sh_d   = ev_en_q;
                re_sh_d   = rise_en_q;
                fe_sh_d   = fall_en_q;
                pin_cnt_d = '0;
                state_d   = ST_SCAN;
              end
            end
            OP_POP: begin
              if (rd_ptr_q == wr_ptr_q) begin
                res_status_d = STAT_EMPTY;
              end else begin
                ram_re  = 1'b1;
                state_d = ST_POP;
              end
            end
            OP_WRITE_ALL: begin
              pin_state_d = (pin_state_q & ~wr_all_mask)
                          | (in_data_word_i[NUM_PINS-1:0] & wr_all_mask);
            end
            OP_WRITE_ONE: begin
              if (pin_bad) begin
                res_status_d = STAT_BAD_PIN;
              end else if (|(pwm_q & pin_sel)) begin
                res_status_d = STAT_PWM_BUSY;
              end else if (!(|(out_mask_q & pin_sel))) begin
                res_status_d = STAT_NOT_OUTPUT;
              end else begin
                pin_state_d = (pin_state_q & ~pin_sel) | (in_pin_value_i ? pin_sel : '0);
              end
            end
            default: ;  // read state and unused codes change nothing
          endcase
        end
      end

      ST_SCAN: begin
        // one pin per cycle, pin state rotates so it is back in place at the end
        lv_sh_d     = lv_sh_q >> 1;
        pv_sh_d     = pv_sh_q >> 1;
        om_sh_d     = om_sh_q >> 1;
        ee_sh_d     = ee_sh_q >> 1;
        re_sh_d     = re_sh_q >> 1;
        fe_sh_d     = fe_sh_q >> 1;
        pin_state_d = (pin_state_q >> 1) | (NUM_PINS'(new_state_bit) << (NUM_PINS - 1));
        if (push_req && !queue_full) begin
          ram_we   = 1'b1;
          wr_ptr_d = wr_next;
        end
        pin_cnt_d = pin_cnt_q + 1'b1;
        if (pin_cnt_q == CntLast) begin
          state_d = ST_FINISH;
        end
      end

      ST_POP: begin
        res_ev_valid_d  = 1'b1;
        res_ev_pin_d    = ram_rdata[EV_REC_W-1:1];
        res_ev_rising_d = ram_rdata[0];
        total_d         = total_q + 1'b1;
        rd_ptr_d        = rd_next;
        state_d         = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d     = 1'b1;
          out_status_d    = res_status_q;
          out_ev_valid_d  = res_ev_valid_q;
          out_ev_pin_d    = res_ev_pin_q;
          out_ev_rising_d = res_ev_rising_q;
          out_total_d     = total_q;
          out_state_d     = WORD_W'(pin_state_q);
          state_d         = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      primed_q    <= 1'b0;
      pin_state_q <= '0;
      prev_q      <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      primed_q    <= primed_d;
      pin_state_q <= pin_state_d;
      prev_q      <= prev_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    lv_sh_q         <= lv_sh_d;
    pv_sh_q         <= pv_sh_d;
    om_sh_q         <= om_sh_d;
    ee_sh_q         <= ee_sh_d;
    re_sh_q         <= re_sh_d;
    fe_sh_q         <= fe_sh_d;
    pin_cnt_q       <= pin_cnt_d;
    res_status_q    <= res_status_d;
    res_ev_valid_q  <= res_ev_valid_d;
    res_ev_pin_q    <= res_ev_pin_d;
    res_ev_rising_q <= res_ev_rising_d;
    out_status_q    <= out_status_d;
    out_ev_valid_q  <= out_ev_valid_d;
    out_ev_pin_q    <= out_ev_pin_d;
    out_ev_rising_q <= out_ev_rising_d;
    out_total_q     <= out_total_d;
    out_state_q     <= out_state_d;
  end

  // ---------------------------------------------------------------------
  // ports
  // ---------------------------------------------------------------------
  assign in_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign out_status_o       = out_status_q;
  assign out_event_valid_o  = out_ev_valid_q;
  assign out_event_pin_o    = out_ev_pin_q;
  assign out_event_rising_o = out_ev_rising_q;
  assign out_event_total_o  = out_total_q;
  assign out_state_word_o   = out_state_q;

endmodule

`default_nettype wire

@@ design/gpioee_ram.sv @@
`default_nettype none

module gpioee_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gpioee_pkg::*;

  localparam int unsigned NUM_PINS    = 24;
  localparam int unsigned QUEUE_DEPTH = 16;
  // worst case is far below this: ~1800 commands in total
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 220;
  localparam logic [WORD_W-1:0] ALL_PINS = 24'hFFFFFF;

  // one command transaction as seen on the input channel
  typedef struct {
    logic [OPCODE_W-1:0]  opcode;
    logic [WORD_W-1:0]    pin_levels;
    logic [WORD_W-1:0]    data_word;
    logic [PIN_IDX_W-1:0] pin_index;
    logic                 pin_value;
  } gpio_command_t;

  // one result transaction as seen on the output channel
  typedef struct {
    status_e              status;
    logic                 event_valid;
    logic [PIN_IDX_W-1:0] event_pin;
    logic                 event_rising;
    logic [TOTAL_W-1:0]   event_total;
    logic [WORD_W-1:0]    state_word;
  } gpio_result_t;

  // shadow of the gpio core: masks, pin state, edge queue and pop count,
  // plus the in-order list of results still owed by the core
  class gpio_event_board;
    logic [WORD_W-1:0]   output_mask;
    logic [WORD_W-1:0]   event_en_mask;
    logic [WORD_W-1:0]   rise_en_mask;
    logic [WORD_W-1:0]   fall_en_mask;
    logic [WORD_W-1:0]   pwm_busy_mask;
    logic [WORD_W-1:0]   pin_state;
    logic [WORD_W-1:0]   prev_levels;
    bit                  primed;
    logic [EV_REC_W-1:0] queued_edges[$];  // {pin, rising}, oldest first
    logic [TOTAL_W-1:0]  popped_total;
    gpio_result_t        awaited_results[$];
    int unsigned         error_count;

    function new();
      output_mask   = '0;
      event_en_mask = '0;
      rise_en_mask  = '0;
      fall_en_mask  = '0;
      pwm_busy_mask = '0;
      pin_state     = '0;
      prev_levels   = '0;
      primed        = 1'b0;
      popped_total  = '0;
      error_count   = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [WORD_W-1:0] value);
      case (idx)
        CFG_OUTPUT_MASK: output_mask   = value;
        CFG_EVENT_EN:    event_en_mask = value;
        CFG_RISE_EN:     rise_en_mask  = value;
        CFG_FALL_EN:     fall_en_mask  = value;
        CFG_PWM_BUSY:    pwm_busy_mask = value;
        default: ;
      endcase
    endfunction

    // ring of QUEUE_DEPTH slots keeps one slot free, new records drop when full
    function void queue_edge(int unsigned pin, logic rising);
      if (queued_edges.size() < QUEUE_DEPTH - 1)
        queued_edges.push_back({pin[PIN_IDX_W-1:0], rising});
    endfunction

    function void sample_pins(logic [WORD_W-1:0] sample);
      logic up;
      if (!primed) begin
        prev_levels = sample;
        primed = 1'b1;
        return;
      end
      for (int unsigned i = 0; i < NUM_PINS; i++) begin
        if (output_mask[i]) begin
          prev_levels[i] = sample[i];
          continue;
        end
        if (sample[i] == prev_levels[i])
          continue;
        up = sample[i];
        pin_state[i] = up;
        if (event_en_mask[i] && (up ? rise_en_mask[i] : fall_en_mask[i]))
          queue_edge(i, up);
        prev_levels[i] = up;
      end
    endfunction

    // work out the result of an accepted command and queue it
    function void note_command(gpio_command_t cmd);
      gpio_result_t        res;
      logic [WORD_W-1:0]   writable;
      logic [EV_REC_W-1:0] rec;
      res.status       = STAT_OK;
      res.event_valid  = 1'b0;
      res.event_pin    = '0;
      res.event_rising = 1'b0;
      case (cmd.opcode)
        OP_POLL: sample_pins(cmd.pin_levels);
        OP_POP: begin
          if (queued_edges.size() == 0) begin
            res.status = STAT_EMPTY;
          end else begin
            rec = queued_edges.pop_front();
            res.event_valid  = 1'b1;
            res.event_pin    = rec[EV_REC_W-1:1];
            res.event_rising = rec[0];
            popped_total++;
          end
        end
        OP_WRITE_ALL: begin
          writable  = output_mask & ~pwm_busy_mask;
          pin_state = (pin_state & ~writable) | (cmd.data_word & writable);
        end
        OP_WRITE_ONE: begin
          if (cmd.pin_index >= NUM_PINS)
            res.status = STAT_BAD_PIN;
          else if (pwm_busy_mask[cmd.pin_index])
            res.status = STAT_PWM_BUSY;
          else if (!output_mask[cmd.pin_index])
            res.status = STAT_NOT_OUTPUT;
          else
            pin_state[cmd.pin_index] = cmd.pin_value;
        end
        default: ;  // read state and the unused codes change nothing
      endcase
      res.event_total = popped_total;
      res.state_word  = pin_state;
      awaited_results.push_back(res);
    endfunction

    function void compare_field(string field, logic [WORD_W-1:0] exp_val,
                                logic [WORD_W-1:0] act_val);
      if (exp_val !== act_val) begin
        $error("%s mismatch: expected %0h, actual %0h", field, exp_val, act_val);
        error_count++;
      end
    endfunction

    function void check_result(gpio_result_t act);
      gpio_result_t exp;
      if (awaited_results.size() == 0) begin
        $error("result transaction with no command outstanding");
        error_count++;
        return;
      end
      exp = awaited_results.pop_front();
      compare_field("status", exp.status, act.status);
      compare_field("event_valid", exp.event_valid, act.event_valid);
      compare_field("event_pin", exp.event_pin, act.event_pin);
      compare_field("event_rising", exp.event_rising, act.event_rising);
      compare_field("event_total", exp.event_total, act.event_total);
      compare_field("state_word", exp.state_word, act.state_word);
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [WORD_W-1:0]    cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [OPCODE_W-1:0]  in_opcode_i;
  logic [WORD_W-1:0]    in_pin_levels_i;
  logic [WORD_W-1:0]    in_data_word_i;
  logic [PIN_IDX_W-1:0] in_pin_index_i;
  logic                 in_pin_value_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [STATUS_W-1:0]  out_status_o;
  logic                 out_event_valid_o;
  logic [PIN_IDX_W-1:0] out_event_pin_o;
  logic                 out_event_rising_o;
  logic [TOTAL_W-1:0]   out_event_total_o;
  logic [WORD_W-1:0]    out_state_word_o;

  gpio_event_board board;
  bit              steady_flow;   // set for the closing stretch: no gaps, no stalls
  logic [WORD_W-1:0] last_sample; // levels of the latest poll, base for small changes
  int unsigned     cycle_count;

  gpio_edge_event_controller_core #(
    .NUM_PINS   (NUM_PINS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_opcode_i       (in_opcode_i),
    .in_pin_levels_i   (in_pin_levels_i),
    .in_data_word_i    (in_data_word_i),
    .in_pin_index_i    (in_pin_index_i),
    .in_pin_value_i    (in_pin_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_status_o      (out_status_o),
    .out_event_valid_o (out_event_valid_o),
    .out_event_pin_o   (out_event_pin_o),
    .out_event_rising_o(out_event_rising_o),
    .out_event_total_o (out_event_total_o),
    .out_state_word_o  (out_state_word_o)
  );

  // 250 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall bursts, then a stretch of ready
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!steady_flow && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(0, 15)) @(posedge clk_i);
    end
  end

  // every result transaction goes to the board; values are the ones before the edge
  always @(posedge clk_i) begin
    gpio_result_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.status       = status_e'(out_status_o);
      seen.event_valid  = out_event_valid_o;
      seen.event_pin    = out_event_pin_o;
      seen.event_rising = out_event_rising_o;
      seen.event_total  = out_event_total_o;
      seen.state_word   = out_state_word_o;
      board.check_result(seen);
    end
  end

  // one register write per cycle; the caller drops the write enable afterwards
  task automatic write_register(cfg_idx_e idx, logic [WORD_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    board.set_register(idx, value);
    @(posedge clk_i);
  endtask

  task automatic load_masks(logic [WORD_W-1:0] outputs, logic [WORD_W-1:0] events,
                            logic [WORD_W-1:0] rises, logic [WORD_W-1:0] falls,
                            logic [WORD_W-1:0] pwm);
    write_register(CFG_OUTPUT_MASK, outputs);
    write_register(CFG_EVENT_EN, events);
    write_register(CFG_RISE_EN, rises);
    write_register(CFG_FALL_EN, falls);
    write_register(CFG_PWM_BUSY, pwm);
    cfg_we_i <= 1'b0;
  endtask

  // present one command transaction, maybe after a gap, and wait for acceptance;
  // valid stays up afterwards so the next command can follow back to back
  task automatic send_command(gpio_command_t cmd);
    int unsigned gap;
    gap = 0;
    if (!steady_flow && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_opcode_i     <= cmd.opcode;
    in_pin_levels_i <= cmd.pin_levels;
    in_data_word_i  <= cmd.data_word;
    in_pin_index_i  <= cmd.pin_index;
    in_pin_value_i  <= cmd.pin_value;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_command(cmd);
  endtask

  // stop sending and let every owed result come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (board.awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic gpio_command_t make_command(logic [OPCODE_W-1:0] opcode,
                                                 logic [WORD_W-1:0] levels,
                                                 logic [WORD_W-1:0] data,
                                                 logic [PIN_IDX_W-1:0] idx,
                                                 logic value);
    gpio_command_t cmd;
    cmd.opcode     = opcode;
    cmd.pin_levels = levels;
    cmd.data_word  = data;
    cmd.pin_index  = idx;
    cmd.pin_value  = value;
    return cmd;
  endfunction

  // mostly polls and pops so the edge queue fills and drains; poll levels
  // often differ from the last sample in a bit or two, like real pins
  function automatic gpio_command_t random_command();
    gpio_command_t cmd;
    int unsigned   pick;
    cmd.pin_levels = WORD_W'($urandom());
    cmd.data_word  = WORD_W'($urandom());
    cmd.pin_index  = ($urandom_range(0, 6) == 0) ? PIN_IDX_W'($urandom_range(NUM_PINS, 31))
                                                 : PIN_IDX_W'($urandom_range(0, NUM_PINS - 1));
    cmd.pin_value  = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 38)
      cmd.opcode = OP_POLL;
    else if (pick < 72)
      cmd.opcode = OP_POP;
    else if (pick < 80)
      cmd.opcode = OP_WRITE_ALL;
    else if (pick < 92)
      cmd.opcode = OP_WRITE_ONE;
    else if (pick < 96)
      cmd.opcode = OP_READ;
    else
      cmd.opcode = OPCODE_W'($urandom_range(OP_READ + 1, 7));  // unused codes
    if (cmd.opcode == OP_POLL) begin
      case ($urandom_range(0, 9))
        0, 1, 2:    cmd.pin_levels = last_sample ^ (24'h1 << $urandom_range(0, 23));
        3, 4:       cmd.pin_levels = last_sample ^ (24'h1 << $urandom_range(0, 23))
                                                 ^ (24'h1 << $urandom_range(0, 23));
        5, 6, 7:    ;  // fully random levels
        8:          cmd.pin_levels = ALL_PINS;
        default:    cmd.pin_levels = '0;
      endcase
      last_sample = cmd.pin_levels;
    end
    return cmd;
  endfunction

  // main sequence
  initial begin
    logic [WORD_W-1:0] masks[5];
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CFG_OUTPUT_MASK;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    in_opcode_i     = OP_POLL;
    in_pin_levels_i = '0;
    in_data_word_i  = '0;
    in_pin_index_i  = '0;
    in_pin_value_i  = 1'b0;
    steady_flow     = 1'b0;
    last_sample     = '0;
    board = new();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: low byte outputs, its low nibble held by pwm,
    // every edge enabled except falls on pins 8 to 11
    load_masks(24'h0000FF, ALL_PINS, ALL_PINS, 24'hFFF0FF, 24'h00000F);
    send_command(make_command(OP_POP, '0, '0, '0, 1'b0));           // empty queue
    send_command(make_command(OP_READ, ALL_PINS, ALL_PINS, 5'd31, 1'b1));
    send_command(make_command(OP_READ + 3'd1, ALL_PINS, ALL_PINS, 5'd31, 1'b1));
    send_command(make_command(OP_READ + 3'd2, '0, ALL_PINS, '0, 1'b0));
    send_command(make_command(OP_READ + 3'd3, ALL_PINS, '0, 5'd31, 1'b1));
    send_command(make_command(OP_POLL, '0, '0, '0, 1'b0));          // priming only
    send_command(make_command(OP_POLL, ALL_PINS, '0, '0, 1'b0));    // 16 rises, queue full
    send_command(make_command(OP_POLL, '0, '0, '0, 1'b0));          // falls all dropped
    send_command(make_command(OP_POP, '0, '0, '0, 1'b0));
    send_command(make_command(OP_POP, '0, '0, '0, 1'b0));
    send_command(make_command(OP_POLL, 24'hFFFF00, '0, '0, 1'b0));  // refills the queue
    send_command(make_command(OP_WRITE_ALL, '0, ALL_PINS, '0, 1'b0));
    send_command(make_command(OP_WRITE_ALL, '0, '0, '0, 1'b0));
    send_command(make_command(OP_WRITE_ONE, '0, '0, 5'd31, 1'b1));  // bad pin
    send_command(make_command(OP_WRITE_ONE, '0, '0, 5'd24, 1'b1));  // bad pin
    send_command(make_command(OP_WRITE_ONE, '0, '0, 5'd0, 1'b1));   // pwm busy
    send_command(make_command(OP_WRITE_ONE, '0, '0, 5'd23, 1'b1));  // input pin
    send_command(make_command(OP_WRITE_ONE, '0, '0, 5'd5, 1'b1));
    send_command(make_command(OP_WRITE_ONE, '0, '0, 5'd7, 1'b1));
    send_command(make_command(OP_WRITE_ONE, '0, '0, 5'd7, 1'b0));
    send_command(make_command(OP_POP, '0, '0, '0, 1'b0));
    send_command(make_command(OP_READ, '0, '0, '0, 1'b0));
    last_sample = 24'hFFFF00;
    drain_results();

    // random phases, each with its own register setting
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      foreach (masks[i]) masks[i] = WORD_W'($urandom());
      case (phase)
        0: masks = '{'0, ALL_PINS, ALL_PINS, ALL_PINS, '0};   // all inputs, all edges
        2: masks = '{ALL_PINS, ALL_PINS, masks[2], masks[3], '0};
        3: masks = '{'0, '0, '0, '0, '0};
        4: masks[0] = masks[0] & WORD_W'($urandom());        // few outputs
        5: masks = '{masks[0], ALL_PINS, '0, ALL_PINS, ALL_PINS};
        default: ;
      endcase
      // closing stretch runs without gaps or stalls
      if (phase == PHASES - 1)
        steady_flow = 1'b1;
      load_masks(masks[0], masks[1], masks[2], masks[3], masks[4]);
      repeat (PHASE_ITEMS) send_command(random_command());
      drain_results();
    end

    repeat (40) @(posedge clk_i);
    if (board.error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
